>>> design/era_pkg.sv
// shared types and constants for the eased rectangle animator
// no dependencies
package era_pkg;

    localparam int COORD_W        = 20;
    localparam int TIME_W         = 32;
    localparam int DUR_W          = 24;
    localparam int CPX_W          = 15;
    localparam int CPY_W          = 16;
    localparam int FRAC_W         = 16;
    localparam int PROG_W         = FRAC_W + 1;
    localparam int ERA_BISECT_STEPS = 10;

    localparam logic [PROG_W-1:0] ONE_Q16 = PROG_W'(1) << FRAC_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [PROG_W-1:0]         prog_t;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

endpackage

>>> design/era_if.sv
// valid/ready channels of the eased rectangle animator
// depends on era_pkg
interface era_req_if import era_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [TIME_W-1:0]     event_time;
    coord_t                end_x;
    coord_t                end_y;
    coord_t                end_w;
    coord_t                end_h;
    logic [DUR_W-1:0]      anim_length;
    logic [CPX_W-1:0]      curve_x1;
    logic signed [CPY_W-1:0] curve_y1;
    logic [CPX_W-1:0]      curve_x2;
    logic signed [CPY_W-1:0] curve_y2;

    modport source (output valid, req_type, event_time, end_x, end_y, end_w, end_h,
                    anim_length, curve_x1, curve_y1, curve_x2, curve_y2,
                    input ready);
    modport sink   (input valid, req_type, event_time, end_x, end_y, end_w, end_h,
                    anim_length, curve_x1, curve_y1, curve_x2, curve_y2,
                    output ready);
endinterface

interface era_rsp_if import era_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t out_x;
    coord_t out_y;
    coord_t out_w;
    coord_t out_h;

    modport source (output valid, out_x, out_y, out_w, out_h, input ready);
    modport sink   (input valid, out_x, out_y, out_w, out_h, output ready);
endinterface

>>> design/eased_rect_animator.sv
// top level of the eased rectangle animator
// depends on era_pkg, era_if (era_req_if, era_rsp_if) and era_div
//
// A start item (req_type 0) is taken without leaving idle: the current rectangle
// becomes the start rectangle, and the target, start time, duration and control
// points are stored; it gives no result. A query item (req_type 1) gives one
// result: zeros while no animation was started, otherwise the blend of start and
// target at the eased progress, which also becomes the current rectangle. A query
// runs through setup, the bit-serial progress divider (sixteen quotient bits, then
// its registered done flag), eight micro-steps on the shared multiplier for each
// Bezier evaluation (one per bisection step plus the final y evaluation), a pass
// of the multiplier for the start and for the target of each of the four
// coordinates of the blend, and the load of the output register. Queries that
// need no easing (idle, zero duration, before start, past end) skip the divider
// and the Bezier passes. The block takes no item while a query is in progress;
// a finished result sits in an output register until taken.
module eased_rect_animator import era_pkg::*;
#(
    parameter int BISECT_STEPS = ERA_BISECT_STEPS
)
(
    input  logic      clk,
    input  logic      rst_n,
    era_req_if.sink   req,
    era_rsp_if.source rsp
);

    localparam int ITER_W = $clog2(BISECT_STEPS + 1);
    localparam int MA_W   = 34;
    localparam int MB_W   = 20;
    localparam int P_W    = MA_W + MB_W;
    localparam int BEZ_W  = 21;
    localparam int E_W    = 19;

    // micro-steps of one bezier evaluation on the shared multiplier
    localparam logic [2:0] STEP_UU  = 3'd0;
    localparam logic [2:0] STEP_TT  = 3'd1;
    localparam logic [2:0] STEP_B1  = 3'd2;
    localparam logic [2:0] STEP_B2  = 3'd3;
    localparam logic [2:0] STEP_B3  = 3'd4;
    localparam logic [2:0] STEP_P1  = 3'd5;
    localparam logic [2:0] STEP_P2  = 3'd6;
    localparam logic [2:0] STEP_SUM = 3'd7;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_BEZ   = 6'b001000,
        ST_BLEND = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // animation state
    coord_t start_reg [4];
    coord_t tgt_reg   [4];
    coord_t cur_reg   [4];
    logic [TIME_W-1:0]       t0_reg;
    logic [DUR_W-1:0]        dur_reg;
    logic                    anim_reg;
    logic [CPX_W-1:0]        x1_reg, x2_reg;
    logic signed [CPY_W-1:0] y1_reg, y2_reg;

    // query working registers
    logic [TIME_W-1:0] now_reg;
    prog_t             p_reg, p_next;
    prog_t             lo_reg, lo_next, hi_reg, hi_next, t_reg, t_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              yph_reg, yph_next;
    logic [2:0]        step_reg, step_next;
    logic [1:0]        idx_reg, idx_next;
    logic              half_reg, half_next;
    logic [PROG_W-1:0] uu_reg, uu_next, tt_reg, tt_next;
    logic [2*PROG_W-2:0] b1_reg, b1_next, b2_reg, b2_next, b3_reg, b3_next;
    logic signed [P_W-1:0] acc_reg, acc_next;
    logic signed [E_W-1:0] e_reg, e_next;
    logic              zero_reg, zero_next;
    coord_t            res_next;
    logic              res_we;

    // output register
    logic   ovalid_reg, ovalid_next;
    coord_t ox_reg, oy_reg, ow_reg, oh_reg;
    logic   oload;

    // shared multiplier
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  prod;

    // divider
    logic               div_start, div_done;
    logic [FRAC_W-1:0]  div_quot;
    logic [TIME_W-1:0]  elapsed;

    logic [PROG_W-1:0]       u_val;
    logic signed [P_W-1:0]   bez_sum;
    logic signed [BEZ_W-1:0] bez;
    logic                    bez_lt;
    logic [PROG_W:0]         mid_sum;
    logic signed [P_W-1:0]   blend_v;
    logic signed [P_W-17:0]  blend_r;
    logic signed [MB_W-1:0]  one_minus_e;
    logic                    in_acc;

    era_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (elapsed[DUR_W-1:0]),
        .den   (dur_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign in_acc      = req.valid && req.ready;
    assign req.ready   = (state_reg == ST_IDLE);
    assign elapsed     = now_reg - t0_reg;
    assign u_val       = ONE_Q16 - t_reg;
    assign one_minus_e = MB_W'(signed'({1'b0, ONE_Q16})) - MB_W'(e_reg);

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_BLEND)
        begin
            if (!half_reg)
            begin
                mul_a = MA_W'(start_reg[idx_reg]);
                mul_b = one_minus_e;
            end
            else
            begin
                mul_a = MA_W'(tgt_reg[idx_reg]);
                mul_b = MB_W'(e_reg);
            end
        end
        else
        begin
            case (step_reg)
                STEP_UU:
                begin
                    mul_a = MA_W'(u_val);
                    mul_b = MB_W'(u_val);
                end
                STEP_TT:
                begin
                    mul_a = MA_W'(t_reg);
                    mul_b = MB_W'(t_reg);
                end
                STEP_B1:
                begin
                    mul_a = MA_W'(uu_reg);
                    mul_b = MB_W'(t_reg);
                end
                STEP_B2:
                begin
                    mul_a = MA_W'(tt_reg);
                    mul_b = MB_W'(u_val);
                end
                STEP_B3:
                begin
                    mul_a = MA_W'(tt_reg);
                    mul_b = MB_W'(t_reg);
                end
                STEP_P1:
                begin
                    mul_a = MA_W'(b1_reg);
                    mul_b = yph_reg ? MB_W'(y1_reg) : MB_W'(x1_reg);
                end
                STEP_P2:
                begin
                    mul_a = MA_W'(b2_reg);
                    mul_b = yph_reg ? MB_W'(y2_reg) : MB_W'(x2_reg);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign prod = mul_a * mul_b;

    // 3 * (b1*p1 + b2*p2) + b3 * 2^14, floored to a signed q4.16 value
    assign bez_sum = (acc_reg <<< 1) + acc_reg + P_W'({b3_reg, 14'b0});
    assign bez     = bez_sum[BEZ_W+29:30];
    assign bez_lt  = bez < BEZ_W'(signed'({1'b0, p_reg}));

    // blend with round half up, then saturate
    assign blend_v = acc_reg + prod + P_W'(32768);
    assign blend_r = blend_v[P_W-1:16];

    always_comb
    begin
        if (blend_r > (P_W-16)'(524287))
        begin
            res_next = coord_t'(524287);
        end
        else if (blend_r < -(P_W-16)'(524288))
        begin
            res_next = coord_t'(-524288);
        end
        else
        begin
            res_next = blend_r[COORD_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        t_next     = t_reg;
        iter_next  = iter_reg;
        yph_next   = yph_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        half_next  = half_reg;
        uu_next    = uu_reg;
        tt_next    = tt_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        b3_next    = b3_reg;
        acc_next   = acc_reg;
        e_next     = e_reg;
        zero_next  = zero_reg;
        div_start  = 1'b0;
        res_we     = 1'b0;
        oload      = 1'b0;
        mid_sum    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && req.req_type == REQ_QUERY)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                idx_next  = '0;
                half_next = 1'b0;
                zero_next = 1'b0;
                if (!anim_reg)
                begin
                    zero_next  = 1'b1;
                    state_next = ST_OUT;
                end
                else if (dur_reg == '0)
                begin
                    e_next     = E_W'(ONE_Q16);
                    state_next = ST_BLEND;
                end
                else if (now_reg < t0_reg)
                begin
                    e_next     = '0;
                    state_next = ST_BLEND;
                end
                else if (elapsed >= TIME_W'(dur_reg))
                begin
                    e_next     = E_W'(ONE_Q16);
                    state_next = ST_BLEND;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    p_next = PROG_W'(div_quot);
                    if (div_quot == '0)
                    begin
                        e_next     = '0;
                        state_next = ST_BLEND;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = ONE_Q16;
                        t_next     = ONE_Q16 >> 1;
                        iter_next  = '0;
                        yph_next   = 1'b0;
                        step_next  = STEP_UU;
                        state_next = ST_BEZ;
                    end
                end
            end
            ST_BEZ:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    STEP_UU:  uu_next = prod[2*FRAC_W:FRAC_W];
                    STEP_TT:  tt_next = prod[2*FRAC_W:FRAC_W];
                    STEP_B1:  b1_next = prod[2*PROG_W-2:0];
                    STEP_B2:  b2_next = prod[2*PROG_W-2:0];
                    STEP_B3:  b3_next = prod[2*PROG_W-2:0];
                    STEP_P1:  acc_next = prod;
                    STEP_P2:  acc_next = acc_reg + prod;
                    STEP_SUM:
                    begin
                        if (yph_reg)
                        begin
                            e_next     = bez[E_W-1:0];
                            state_next = ST_BLEND;
                        end
                        else
                        begin
                            if (bez_lt)
                            begin
                                lo_next = t_reg;
                            end
                            else
                            begin
                                hi_next = t_reg;
                            end
                            mid_sum   = {1'b0, lo_next} + {1'b0, hi_next};
                            t_next    = mid_sum[PROG_W:1];
                            iter_next = iter_reg + ITER_W'(1);
                            if (iter_reg == ITER_W'(BISECT_STEPS - 1))
                            begin
                                yph_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        step_next = STEP_UU;
                    end
                endcase
            end
            ST_BLEND:
            begin
                half_next = !half_reg;
                if (!half_reg)
                begin
                    acc_next = prod;
                end
                else
                begin
                    res_we   = 1'b1;
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    oload      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (oload)
        begin
            ovalid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    // control and animation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            anim_reg   <= 1'b0;
            t0_reg     <= '0;
            dur_reg    <= '0;
            x1_reg     <= '0;
            y1_reg     <= '0;
            x2_reg     <= '0;
            y2_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                start_reg[i] <= '0;
                tgt_reg[i]   <= '0;
                cur_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (in_acc && req.req_type == REQ_START)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    start_reg[i] <= cur_reg[i];
                end
                tgt_reg[0] <= req.end_x;
                tgt_reg[1] <= req.end_y;
                tgt_reg[2] <= req.end_w;
                tgt_reg[3] <= req.end_h;
                t0_reg     <= req.event_time;
                dur_reg    <= req.anim_length;
                x1_reg     <= req.curve_x1;
                y1_reg     <= req.curve_y1;
                x2_reg     <= req.curve_x2;
                y2_reg     <= req.curve_y2;
                anim_reg   <= 1'b1;
            end
            if (res_we)
            begin
                cur_reg[idx_reg] <= res_next;
            end
        end
    end

    // working registers of a query
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            now_reg <= req.event_time;
        end
        p_reg    <= p_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        t_reg    <= t_next;
        iter_reg <= iter_next;
        yph_reg  <= yph_next;
        step_reg <= step_next;
        idx_reg  <= idx_next;
        half_reg <= half_next;
        uu_reg   <= uu_next;
        tt_reg   <= tt_next;
        b1_reg   <= b1_next;
        b2_reg   <= b2_next;
        b3_reg   <= b3_next;
        acc_reg  <= acc_next;
        e_reg    <= e_next;
        zero_reg <= zero_next;
        if (oload)
        begin
            ox_reg <= zero_reg ? '0 : cur_reg[0];
            oy_reg <= zero_reg ? '0 : cur_reg[1];
            ow_reg <= zero_reg ? '0 : cur_reg[2];
            oh_reg <= zero_reg ? '0 : cur_reg[3];
        end
    end

    assign rsp.valid = ovalid_reg;
    assign rsp.out_x = ox_reg;
    assign rsp.out_y = oy_reg;
    assign rsp.out_w = ow_reg;
    assign rsp.out_h = oh_reg;

endmodule

>>> design/era_div.sv
// restoring divider for progress, one quotient bit per cycle
// depends on era_pkg
module era_div import era_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DUR_W-1:0]   num,
    input  logic [DUR_W-1:0]   den,
    output logic               done,
    output logic [FRAC_W-1:0]  quot
);

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic [FRAC_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DUR_W:0]    shifted;
    logic [DUR_W:0]    diff;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        diff      = shifted - {1'b0, den};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            quot_next = '0;
            cnt_next  = CNT_W'(FRAC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DUR_W])
            begin
                rem_next  = diff[DUR_W-1:0];
                quot_next = {quot_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DUR_W-1:0];
                quot_next = {quot_reg[FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
